@@ hdl/bounded_integer_set_table_defines.svh @@
// assertion macros shared by the set table rtl
`ifndef BOUNDED_INTEGER_SET_TABLE_DEFINES_SVH
`define BOUNDED_INTEGER_SET_TABLE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define BIST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// condition that must hold whenever the antecedent is seen
`define BIST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/bist_pkg.sv @@
// shared types and constants of the bounded integer set table
package bist_pkg;

    localparam int VALUE_W       = 32;
    localparam int CAP_W         = 7;
    localparam int OUT_W         = 7;
    localparam int DEPTH_DEFAULT = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // operation token walking down the row of cells
    typedef struct packed {
        logic               vld;
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic               full;
        logic               found;
    } tok_t;

    // entry handed from a cell to its lower neighbour on erase
    typedef struct packed {
        logic               req;
        logic [VALUE_W-1:0] data;
    } shift_t;

endpackage

@@ hdl/bist_cell.sv @@
// one storage cell of the set table: holds one entry and passes the token on
module bist_cell #(
    parameter int DEPTH = bist_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [$clog2(DEPTH+1)-1:0]  count,
    input  bist_pkg::tok_t              tok_in,
    input  logic [$clog2(DEPTH+1)-1:0]  pos_in,
    input  bist_pkg::shift_t            shift_in,
    output bist_pkg::tok_t              tok_out,
    output logic [$clog2(DEPTH+1)-1:0]  pos_out,
    output bist_pkg::shift_t            shift_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [CW-1:0] POS_C = CW'(IDX + 1);

    bist_pkg::tok_t                  tok_reg;
    logic [CW-1:0]                   pos_reg;
    logic [bist_pkg::VALUE_W-1:0]    entry_reg;
    logic [bist_pkg::VALUE_W-1:0]    entry_next;
    logic                            live;
    logic                            hit;
    logic                            do_insert;

    // token and position move one cell per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            pos_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_in;
            pos_reg <= pos_in;
        end
    end

    // compare against the held entry
    always_comb
    begin
        live      = IDX_C < count;
        hit       = tok_reg.vld && live && (entry_reg == tok_reg.value);
        do_insert = advance && tok_reg.vld && (tok_reg.op == bist_pkg::OP_INSERT)
                    && !tok_reg.found && !tok_reg.full && (IDX_C == count);
    end

    // pass the token on with match result folded in
    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.found = tok_reg.found | hit;
        pos_out       = hit ? POS_C : pos_reg;
    end

    // later entries close the gap left by an erased one
    always_comb
    begin
        shift_out.req  = advance && tok_reg.vld && (tok_reg.op == bist_pkg::OP_ERASE)
                         && tok_reg.found && live;
        shift_out.data = entry_reg;
    end

    // entry update: append on insert, take the upper neighbour on erase
    always_comb
    begin
        entry_next = entry_reg;
        if (do_insert)
        begin
            entry_next = tok_reg.value;
        end
        else if (shift_in.req)
        begin
            entry_next = shift_in.data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ hdl/bounded_integer_set_table.sv @@
// top level of the bounded integer set table: row of cells and result stage
//
//  channel  | handshake          | payload
//  req      | req_valid/stall    | operation, value
//  rsp      | rsp_valid/stall    | status, found, position, entry_count
//  cap      | cap_wr_en          | cap_wr_data
//
// an operation token walks the row one cell per cycle; the result is registered
// when the token leaves the last cell, and the next request is taken only once
// it has left, so the block holds one operation at a time.
// reset empties the set and sets the capacity to 64; entries need no clearing.
// a stalled result holds the token in the last cell until it is taken.
module bounded_integer_set_table #(
    parameter int DEPTH = bist_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [1:0]                          operation,
    input  logic signed [bist_pkg::VALUE_W-1:0] value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [1:0]                          status,
    output logic                                found,
    output logic [bist_pkg::OUT_W-1:0]          position,
    output logic [bist_pkg::OUT_W-1:0]          entry_count,
    input  logic                                cap_wr_en,
    input  logic [bist_pkg::CAP_W-1:0]          cap_wr_data
);

    `include "bounded_integer_set_table_defines.svh"

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CMW = (CW > bist_pkg::CAP_W) ? CW : bist_pkg::CAP_W;
    localparam int OW  = bist_pkg::OUT_W;

    logic [bist_pkg::CAP_W-1:0]  cap_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        busy_reg;
    logic                        rsp_valid_reg;
    bist_pkg::status_t           status_reg;
    bist_pkg::status_t           status_next;
    logic                        found_reg;
    logic [bist_pkg::OUT_W-1:0]  position_reg;
    logic [bist_pkg::OUT_W-1:0]  entry_count_reg;
    logic                        req_beat;
    logic                        advance;
    logic                        exit_beat;
    logic                        full;
    bist_pkg::tok_t              tok_link   [0:DEPTH];
    logic [CW-1:0]               pos_link   [0:DEPTH];
    bist_pkg::shift_t            shift_link [0:DEPTH];

    // handshake and chain enable
    always_comb
    begin
        req_stall = busy_reg;
        req_beat  = req_valid && !busy_reg;
        advance   = !(tok_link[DEPTH].vld && rsp_valid_reg && rsp_stall);
        exit_beat = advance && tok_link[DEPTH].vld;
        full      = (CMW'(count_reg) >= CMW'(cap_reg)) || (count_reg >= CW'(DEPTH));
    end

    // token entering the first cell
    always_comb
    begin
        tok_link[0].vld   = req_beat;
        tok_link[0].op    = bist_pkg::op_t'(operation);
        tok_link[0].value = $unsigned(value);
        tok_link[0].full  = full;
        tok_link[0].found = 1'b0;
        pos_link[0]       = '0;
        shift_link[DEPTH] = '0;
    end

    // row of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            bist_cell #(
                .DEPTH (DEPTH),
                .IDX   (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .count     (count_reg),
                .tok_in    (tok_link[gi]),
                .pos_in    (pos_link[gi]),
                .shift_in  (shift_link[gi+1]),
                .tok_out   (tok_link[gi+1]),
                .pos_out   (pos_link[gi+1]),
                .shift_out (shift_link[gi])
            );
        end
    endgenerate

    // count and status once the token leaves the row
    always_comb
    begin
        count_next  = count_reg;
        status_next = bist_pkg::ST_OK;
        case (tok_link[DEPTH].op)
            bist_pkg::OP_INSERT:
            begin
                if (!tok_link[DEPTH].found)
                begin
                    if (tok_link[DEPTH].full)
                    begin
                        status_next = bist_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = CW'(count_reg + 1'b1);
                    end
                end
            end
            bist_pkg::OP_ERASE:
            begin
                if (tok_link[DEPTH].found)
                begin
                    count_next = CW'(count_reg - 1'b1);
                end
                else
                begin
                    status_next = bist_pkg::ST_NOT_FOUND;
                end
            end
            bist_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= bist_pkg::CAP_RESET;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cap_wr_en)
            begin
                cap_reg <= cap_wr_data;
            end
            if (exit_beat)
            begin
                count_reg <= count_next;
            end
            if (req_beat)
            begin
                busy_reg <= 1'b1;
            end
            else if (exit_beat)
            begin
                busy_reg <= 1'b0;
            end
            if (exit_beat)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (exit_beat)
        begin
            status_reg      <= status_next;
            found_reg       <= tok_link[DEPTH].found;
            position_reg    <= OW'(pos_link[DEPTH]);
            entry_count_reg <= OW'(count_next);
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

    // checks
    `BIST_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "count beyond depth")
    `BIST_ASSERT_ALWAYS(a_no_shift_below, !shift_link[0].req, "shift out of first cell")
    `BIST_ASSERT_IMPL(a_idle_empty, !busy_reg, !tok_link[DEPTH].vld, "token while idle")
    `BIST_ASSERT_IMPL(a_full_absent, rsp_valid && status == bist_pkg::ST_FULL,
                      !found && position == '0, "full result with a position")
    `BIST_ASSERT_IMPL(a_found_pos, exit_beat && tok_link[DEPTH].found,
                      pos_link[DEPTH] != '0, "found with no position")

endmodule

@@ bench/tb_bounded_integer_set_table.sv @@
// self-checking testbench for the bounded integer set table
`timescale 1ns / 100ps

module tb_bounded_integer_set_table;

    import bist_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 96;

    // one expected result beat
    typedef struct {
        logic [1:0]       status;
        logic             found;
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] entry_count;
    } set_result_t;

    // tracks set membership and the results still owed by the block
    class membership_scoreboard;
        logic [VALUE_W-1:0] held_values[$];
        logic [CAP_W-1:0]   capacity;
        set_result_t        pending_results[$];
        int                 errors;
        int                 checked;
        int                 refused_inserts;
        int                 absent_erases;

        function new();
            capacity        = CAP_RESET;
            errors          = 0;
            checked         = 0;
            refused_inserts = 0;
            absent_erases   = 0;
        endfunction

        // work out the result of one accepted request beat
        function void note_request(op_t op, logic [VALUE_W-1:0] v);
            set_result_t exp;
            int          idx;
            idx = -1;
            for (int i = 0; i < held_values.size(); i++)
            begin
                if (idx < 0 && held_values[i] == v)
                    idx = i;
            end
            exp.status   = ST_OK;
            exp.found    = (idx >= 0);
            exp.position = (idx >= 0) ? OUT_W'(idx + 1) : '0;
            case (op)
                OP_INSERT:
                begin
                    if (idx < 0)
                    begin
                        if (held_values.size() >= capacity || held_values.size() >= DEPTH)
                        begin
                            exp.status = ST_FULL;
                            refused_inserts++;
                        end
                        else
                            held_values.push_back(v);
                    end
                end
                OP_ERASE:
                begin
                    if (idx < 0)
                    begin
                        exp.status = ST_NOT_FOUND;
                        absent_erases++;
                    end
                    else
                        held_values.delete(idx);
                end
                OP_CLEAR:
                    held_values.delete();
                default: ;
            endcase
            exp.entry_count = OUT_W'(held_values.size());
            pending_results.push_back(exp);
        endfunction

        // compare one result beat against the oldest expectation
        function void check_result(logic [1:0] st, logic fnd, logic [OUT_W-1:0] pos,
                                   logic [OUT_W-1:0] cnt);
            set_result_t exp;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected (status %0d count %0d)",
                         $time, st, cnt);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            if (st !== exp.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, exp.status, st);
                errors++;
            end
            if (fnd !== exp.found)
            begin
                $display("%0t: found expected %0d got %0d", $time, exp.found, fnd);
                errors++;
            end
            if (pos !== exp.position)
            begin
                $display("%0t: position expected %0d got %0d", $time, exp.position, pos);
                errors++;
            end
            if (cnt !== exp.entry_count)
            begin
                $display("%0t: entry_count expected %0d got %0d", $time, exp.entry_count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      req_valid   = 1'b0;
    logic                      req_stall;
    logic [1:0]                operation   = OP_QUERY;
    logic signed [VALUE_W-1:0] value       = '0;
    logic                      rsp_valid;
    logic                      rsp_stall   = 1'b0;
    logic [1:0]                status;
    logic                      found;
    logic [OUT_W-1:0]          position;
    logic [OUT_W-1:0]          entry_count;
    logic                      cap_wr_en   = 1'b0;
    logic [CAP_W-1:0]          cap_wr_data = '0;

    membership_scoreboard sb = new();

    logic [VALUE_W-1:0] value_pool[POOL_SIZE];
    int                 burst_left = 0;
    int                 cap_settings = 1;
    int                 cycle_count = 0;

    bounded_integer_set_table #(.DEPTH(DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .found       (found),
        .position    (position),
        .entry_count (entry_count),
        .cap_wr_en   (cap_wr_en),
        .cap_wr_data (cap_wr_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[bounded_integer_set_table] ERROR");
            $finish;
        end
    end

    // result side: check taken beats, then stall in changing modes
    int stall_mode = 0;
    int mode_left  = 0;
    int run_left   = 0;
    bit run_level  = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(status, found, position, entry_count);
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 40);
            default:
            begin
                if (run_left == 0)
                begin
                    run_left  = $urandom_range(1, 15);
                    run_level = !run_level;
                end
                run_left--;
                rsp_stall <= run_level;
            end
        endcase
    end

    // send one request beat, opening a new burst after a random gap when due
    task automatic send_request(op_t op, logic [VALUE_W-1:0] v);
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 6);
        end
        req_valid <= 1'b1;
        operation <= op;
        value     <= v;
        do @(posedge clk); while (req_stall);
        sb.note_request(op, v);
        burst_left--;
    endtask

    // let every owed result come back with the request side quiet
    task automatic drain();
        req_valid  <= 1'b0;
        burst_left = 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    // write the capacity register while the block is idle
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain();
        cap_wr_en   <= 1'b1;
        cap_wr_data <= cap;
        @(posedge clk);
        sb.capacity = cap;
        cap_wr_en <= 1'b0;
        cap_settings++;
    endtask

    // random mix of well-formed operations on a pool of recurring values
    task automatic run_random(int n, int insert_pct, int pool_n);
        int                 r;
        op_t                op;
        logic [VALUE_W-1:0] v;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                op = OP_INSERT;
            else if (r >= 98)
                op = OP_CLEAR;
            else if (r[0])
                op = OP_ERASE;
            else
                op = OP_QUERY;
            if ($urandom_range(0, 9) == 0)
                v = $urandom;
            else
                v = value_pool[$urandom_range(0, pool_n - 1)];
            send_request(op, v);
        end
    endtask

    // main sequence
    initial
    begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, duplicates, erase with shift, clear on non-empty and empty set
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h7fff_ffff);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hffff_ffff);
        send_request(OP_INSERT, 32'hffff_ffff);
        send_request(OP_QUERY,  32'h7fff_ffff);
        send_request(OP_QUERY,  32'd12345);
        send_request(OP_ERASE,  32'h7fff_ffff);
        send_request(OP_QUERY,  32'hffff_ffff);
        send_request(OP_ERASE,  32'h7fff_ffff);
        send_request(OP_ERASE,  32'h8000_0000);
        send_request(OP_CLEAR,  32'h0000_0000);
        send_request(OP_QUERY,  32'h0000_0000);
        send_request(OP_CLEAR,  32'h0000_0000);

        // full set, duplicate into a full set
        write_capacity(7'd2);
        send_request(OP_INSERT, 32'haaaa_aaaa);
        send_request(OP_INSERT, 32'h5555_5555);
        send_request(OP_INSERT, 32'd7);
        send_request(OP_INSERT, 32'h5555_5555);

        // capacity below the current count
        write_capacity(7'd1);
        send_request(OP_INSERT, 32'd9);
        send_request(OP_ERASE,  32'haaaa_aaaa);
        send_request(OP_INSERT, 32'd9);
        send_request(OP_ERASE,  32'h5555_5555);
        send_request(OP_INSERT, 32'd9);

        // zero capacity
        write_capacity(7'd0);
        send_request(OP_INSERT, 32'd11);
        send_request(OP_QUERY,  32'd9);

        // random phases over a spread of capacities
        write_capacity(7'd127);
        run_random(110, 65, 90);
        write_capacity(7'd1);
        run_random(40, 40, 8);
        write_capacity(7'd0);
        run_random(30, 50, 8);
        write_capacity(7'd5);
        run_random(70, 45, 12);
        write_capacity(7'd16);
        run_random(80, 50, 24);
        write_capacity(7'd64);
        run_random(90, 60, 70);
        write_capacity(CAP_W'($urandom_range(1, 64)));
        run_random(30, 50, 40);

        drain();
        repeat (DEPTH + 8) @(posedge clk);

        $display("checked %0d results across %0d capacity settings", sb.checked, cap_settings);
        $display("%0d inserts refused as full, %0d erases of absent values",
                 sb.refused_inserts, sb.absent_erases);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("[bounded_integer_set_table] OK");
        else
            $display("[bounded_integer_set_table] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/bist_pkg.sv
hdl/bist_cell.sv
hdl/bounded_integer_set_table.sv
bench/tb_bounded_integer_set_table.sv
